// File: rtl/core/separable_gaussian_blur_defines.svh
// Assertion macros for the blur core.
`ifndef SEPARABLE_GAUSSIAN_BLUR_DEFINES_SVH
`define SEPARABLE_GAUSSIAN_BLUR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define SGB_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define SGB_NEVER(lbl, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);
`else
`define SGB_ASSERT(lbl, prop, msg)
`define SGB_NEVER(lbl, expr, msg)
`endif

`endif

// File: rtl/core/sgb_pkg.sv
package sgb_pkg;

	localparam int RADIUS_DEF     = 5;
	localparam int MAX_WIDTH_DEF  = 512;
	localparam int MAX_HEIGHT_DEF = 512;
	localparam int CHANNELS_DEF   = 3;

	localparam int DIM_REG_W  = 10;
	localparam int COEF_W     = 16;
	localparam int CFG_IDX_W  = 3;
	localparam int SAMPLE_W   = 8;
	localparam int TAP_W      = 4;
	localparam int DIST_W     = 3;
	localparam int NUM_COEF   = 6;
	localparam int FRAC_BITS  = 15;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_CENTER  = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_OFF1    = 3'd3;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_OFF2    = 3'd4;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_OFF3    = 3'd5;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_OFF4    = 3'd6;
	localparam logic [CFG_IDX_W-1:0] REG_COEF_OFF5    = 3'd7;

	localparam logic [DIM_REG_W-1:0] DIM_RESET = 10'd512;
	localparam logic [COEF_W-1:0] COEF_RESET [NUM_COEF] = '{
		16'd6572, 16'd5800, 16'd3986, 16'd2134, 16'd889, 16'd289
	};

	localparam logic OP_LOAD  = 1'b0;
	localparam logic OP_DRAIN = 1'b1;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_H_ISSUE,
		ST_H_WAIT,
		ST_H_WRITE,
		ST_D_DIVW,
		ST_V_ISSUE,
		ST_V_WAIT,
		ST_V_EMIT
	} sgb_state_t;

	typedef struct packed {
		logic             load_wr;
		logic             h_init;
		logic             d_init;
		logic             issue;
		logic             acc_clr;
		logic             h_write;
		logic             emit;
		logic [TAP_W-1:0] tap;
	} sgb_cmd_t;

	typedef struct packed {
		logic load_full;
		logic pipe_busy;
		logic h_last;
		logic div_done;
		logic drain_last;
		logic cfg_settle;
	} sgb_status_t;

endpackage

// File: rtl/core/sgb_div.sv
module sgb_div import sgb_pkg::*; #(
	parameter int N   = 20,
	parameter int DVW = 10
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  logic [N-1:0]   dividend,
	input  logic [DVW-1:0] divisor,
	output logic [N-1:0]   quotient,
	output logic [DVW-1:0] remainder,
	output logic           done
);

	localparam int CNT_W = $clog2(N + 1);

	logic [DVW-1:0]   rem_q;
	logic [N-1:0]     quo_q;
	logic [DVW-1:0]   div_q;
	logic [CNT_W-1:0] cnt_q;
	logic             run_q;
	logic             done_q;
	logic [DVW:0]     rem_sh;
	logic [DVW:0]     rem_sub;
	logic             ge;

	always_comb begin
		rem_sh  = {rem_q, quo_q[N-1]};
		ge      = rem_sh >= {1'b0, div_q};
		rem_sub = ge ? (rem_sh - {1'b0, div_q}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q  <= '0;
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else if (start) begin
			cnt_q  <= CNT_W'(N);
			run_q  <= 1'b1;
			done_q <= 1'b0;
		end else if (run_q) begin
			cnt_q  <= cnt_q - 1'b1;
			run_q  <= cnt_q != CNT_W'(1);
			done_q <= cnt_q == CNT_W'(1);
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			div_q <= divisor;
		end else if (run_q) begin
			rem_q <= rem_sub[DVW-1:0];
			quo_q <= {quo_q[N-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign done      = done_q;

endmodule

// File: rtl/core/sgb_datapath.sv
module sgb_datapath import sgb_pkg::*; #(
	parameter int RADIUS     = RADIUS_DEF,
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int CHANNELS   = CHANNELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  sgb_cmd_t             cmd,
	output sgb_status_t          status,
	input  logic [SAMPLE_W-1:0]  sample_in,
	input  logic                 cfg_valid,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data,
	output logic                 strobe,
	output logic [SAMPLE_W-1:0]  blurred,
	output logic                 frame_last
);

	localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT * CHANNELS;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int XW     = $clog2(MAX_WIDTH);
	localparam int YW     = $clog2(MAX_HEIGHT);
	localparam int DWW    = $clog2(MAX_WIDTH + 1);
	localparam int DHW    = $clog2(MAX_HEIGHT + 1);
	localparam int PW     = $clog2(MAX_WIDTH * MAX_HEIGHT);
	localparam int CW     = ((XW > YW) ? XW : YW) + 2;
	localparam int CHW    = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int PROD_W = SAMPLE_W + COEF_W;
	localparam int ACC_W  = PROD_W + $clog2(2 * RADIUS + 1);
	localparam int Q_W    = ACC_W - FRAC_BITS;
	localparam int EXT_W  = 14;

	// configuration
	logic [DIM_REG_W-1:0] width_q, height_q;
	logic [COEF_W-1:0]    coef_q [NUM_COEF];
	logic                 settle_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= DIM_RESET;
			height_q <= DIM_RESET;
			coef_q   <= COEF_RESET;
			settle_q <= 1'b1;
		end else begin
			settle_q <= cfg_valid;
			if (cfg_valid) begin
				unique case (cfg_index)
					REG_IMAGE_WIDTH:  width_q   <= cfg_data[DIM_REG_W-1:0];
					REG_IMAGE_HEIGHT: height_q  <= cfg_data[DIM_REG_W-1:0];
					REG_COEF_CENTER:  coef_q[0] <= cfg_data;
					REG_COEF_OFF1:    coef_q[1] <= cfg_data;
					REG_COEF_OFF2:    coef_q[2] <= cfg_data;
					REG_COEF_OFF3:    coef_q[3] <= cfg_data;
					REG_COEF_OFF4:    coef_q[4] <= cfg_data;
					REG_COEF_OFF5:    coef_q[5] <= cfg_data;
					default: ;
				endcase
			end
		end
	end

	logic [DWW-1:0]       w_eff;
	logic [DHW-1:0]       h_eff;
	logic [EXT_W-1:0]     w_ext, h_ext;
	logic [DWW+DHW-1:0]   wh_q;
	logic [CNT_W-1:0]     total;

	always_comb begin
		w_ext = EXT_W'(width_q);
		h_ext = EXT_W'(height_q);
		if (w_ext == '0)                    w_eff = DWW'(1);
		else if (w_ext > EXT_W'(MAX_WIDTH)) w_eff = DWW'(MAX_WIDTH);
		else                                w_eff = DWW'(w_ext);
		if (h_ext == '0)                     h_eff = DHW'(1);
		else if (h_ext > EXT_W'(MAX_HEIGHT)) h_eff = DHW'(MAX_HEIGHT);
		else                                 h_eff = DHW'(h_ext);
	end

	always_ff @(posedge clk) begin
		wh_q <= (DWW+DHW)'(w_eff) * (DWW+DHW)'(h_eff);
	end

	assign total = CNT_W'(wh_q) * CNT_W'(CHANNELS);

	// counters
	logic [CNT_W-1:0]  load_cnt_q;
	logic [PW-1:0]     emit_pix_q;
	logic [CHW-1:0]    emit_ch_q;
	logic [CNT_W:0]    load_nx;
	logic              load_room;
	logic [XW-1:0]     hx_q, vx_q;
	logic [YW-1:0]     hy_q, vy_q;
	logic [CHW-1:0]    hc_q, vc_q;
	logic [ADDR_W-1:0] hidx_q;
	logic              vert_q, last_q;
	logic              h_last;
	logic [SAMPLE_W-1:0] fin;

	assign load_nx   = {1'b0, load_cnt_q} + 1'b1;
	assign load_room = load_cnt_q < total;
	assign h_last    = (XW'(w_eff - 1'b1) == hx_q) && (YW'(h_eff - 1'b1) == hy_q)
		&& (hc_q == CHW'(CHANNELS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			load_cnt_q <= '0;
			emit_pix_q <= '0;
			emit_ch_q  <= '0;
		end else begin
			if (cmd.load_wr && load_room) begin
				load_cnt_q <= load_cnt_q + 1'b1;
			end
			if (cmd.emit) begin
				if (last_q) begin
					emit_pix_q <= '0;
					emit_ch_q  <= '0;
					load_cnt_q <= '0;
				end else if (emit_ch_q == CHW'(CHANNELS - 1)) begin
					emit_ch_q  <= '0;
					emit_pix_q <= emit_pix_q + 1'b1;
				end else begin
					emit_ch_q <= emit_ch_q + 1'b1;
				end
			end
		end
	end

	// drain position: pixel and channel counted apart, pixel split by the row width
	logic              emit_in_range;
	logic [PW-1:0]     drain_pix;
	logic [CHW-1:0]    drain_ch;
	logic              drain_last;
	logic [PW-1:0]     div_quot;
	logic [DWW-1:0]    div_rem;
	logic              div_done;

	assign emit_in_range = (DWW+DHW)'(emit_pix_q) < wh_q;
	assign drain_pix     = emit_in_range ? emit_pix_q : PW'(wh_q - 1'b1);
	assign drain_ch      = emit_in_range ? emit_ch_q : CHW'(CHANNELS - 1);
	assign drain_last    = !emit_in_range
		|| ((emit_pix_q == PW'(wh_q - 1'b1)) && (emit_ch_q == CHW'(CHANNELS - 1)));

	sgb_div #(.N(PW), .DVW(DWW)) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.d_init),
		.dividend  (drain_pix),
		.divisor   (w_eff),
		.quotient  (div_quot),
		.remainder (div_rem),
		.done      (div_done)
	);

	always_ff @(posedge clk) begin
		if (cmd.h_init) begin
			hx_q   <= '0;
			hy_q   <= '0;
			hc_q   <= '0;
			hidx_q <= '0;
			vert_q <= 1'b0;
		end else if (cmd.h_write) begin
			hidx_q <= hidx_q + 1'b1;
			if (hc_q == CHW'(CHANNELS - 1)) begin
				hc_q <= '0;
				if (hx_q == XW'(w_eff - 1'b1)) begin
					hx_q <= '0;
					hy_q <= hy_q + 1'b1;
				end else begin
					hx_q <= hx_q + 1'b1;
				end
			end else begin
				hc_q <= hc_q + 1'b1;
			end
		end
		if (cmd.d_init) begin
			vert_q <= 1'b1;
			vc_q   <= drain_ch;
			last_q <= drain_last;
		end
		if (div_done) begin
			vx_q <= XW'(div_rem);
			vy_q <= YW'(div_quot);
		end
	end

	// tap pipeline
	logic signed [CW-1:0] off, t;
	logic [DIST_W-1:0]    tap_dist;
	logic [XW-1:0]        col_c;
	logic [YW-1:0]        row_c;

	always_comb begin
		off      = $signed(CW'(cmd.tap)) - $signed(CW'(RADIUS));
		tap_dist = (off < 0) ? DIST_W'(-off) : DIST_W'(off);
		t    = vert_q ? ($signed(CW'(vy_q)) + off) : ($signed(CW'(hx_q)) + off);
		col_c = vert_q ? vx_q : hx_q;
		row_c = vert_q ? vy_q : hy_q;
		if (vert_q) begin
			if (t < 0)                          row_c = '0;
			else if (t >= $signed(CW'(h_eff))) row_c = YW'(h_eff - 1'b1);
			else                                row_c = YW'(t);
		end else begin
			if (t < 0)                          col_c = '0;
			else if (t >= $signed(CW'(w_eff))) col_c = XW'(w_eff - 1'b1);
			else                                col_c = XW'(t);
		end
	end

	logic [YW-1:0]       row_s1;
	logic [XW-1:0]       col_s1;
	logic [PW-1:0]       m_s2;
	logic [ADDR_W-1:0]   addr_s3;
	logic [SAMPLE_W-1:0] fr_rd_s4, rp_rd_s4, rd_s4;
	logic [PROD_W-1:0]   prod_s5;
	logic [DIST_W-1:0]   d_s1, d_s2, d_s3, d_s4;
	logic                v_s1, v_s2, v_s3, v_s4, v_s5;
	logic [ACC_W-1:0]    acc_q;
	logic [CHW-1:0]      chan;

	assign chan = vert_q ? vc_q : hc_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		row_s1  <= row_c;
		col_s1  <= col_c;
		d_s1    <= tap_dist;
		m_s2    <= PW'(row_s1) * PW'(w_eff) + PW'(col_s1);
		d_s2    <= d_s1;
		addr_s3 <= ADDR_W'(m_s2) * ADDR_W'(CHANNELS) + ADDR_W'(chan);
		d_s3    <= d_s2;
		d_s4    <= d_s3;
		prod_s5 <= PROD_W'(rd_s4) * PROD_W'(coef_q[d_s4]);
		if (cmd.acc_clr) begin
			acc_q <= '0;
		end else if (v_s5) begin
			acc_q <= acc_q + ACC_W'(prod_s5);
		end
	end

	assign rd_s4 = vert_q ? rp_rd_s4 : fr_rd_s4;

	// frame and row-pass stores
	logic [SAMPLE_W-1:0] frame_mem [DEPTH];
	logic [SAMPLE_W-1:0] rowp_mem [DEPTH];

	always_ff @(posedge clk) begin
		if (cmd.load_wr && load_room) begin
			frame_mem[load_cnt_q[ADDR_W-1:0]] <= sample_in;
		end
		fr_rd_s4 <= frame_mem[addr_s3];
	end

	always_ff @(posedge clk) begin
		if (cmd.h_write) begin
			rowp_mem[hidx_q] <= fin;
		end
		rp_rd_s4 <= rowp_mem[addr_s3];
	end

	logic [Q_W-1:0] q_val;

	always_comb begin
		q_val = acc_q[ACC_W-1:FRAC_BITS];
		fin   = (q_val > Q_W'(255)) ? 8'hFF : q_val[SAMPLE_W-1:0];
	end

	// result register
	logic                strobe_q, frame_last_q;
	logic [SAMPLE_W-1:0] blurred_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= cmd.emit;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			blurred_q    <= fin;
			frame_last_q <= last_q;
		end
	end

	assign strobe     = strobe_q;
	assign blurred    = blurred_q;
	assign frame_last = frame_last_q;

	assign status.load_full  = load_nx >= {1'b0, total};
	assign status.pipe_busy  = v_s1 | v_s2 | v_s3 | v_s4 | v_s5;
	assign status.h_last     = h_last;
	assign status.div_done   = div_done;
	assign status.drain_last = last_q;
	assign status.cfg_settle = settle_q;

endmodule

// File: rtl/core/sgb_ctrl.sv
`include "separable_gaussian_blur_defines.svh"

module sgb_ctrl import sgb_pkg::*; #(
	parameter int RADIUS = RADIUS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	input  logic        opcode,
	output logic        busy,
	output sgb_cmd_t    cmd,
	input  sgb_status_t status
);

	localparam logic [TAP_W-1:0] LAST_TAP = TAP_W'(2 * RADIUS);

	sgb_state_t       state_q, state_nx;
	logic [TAP_W-1:0] tap_q, tap_nx;
	logic             loaded_q, loaded_nx;
	logic             req;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			tap_q    <= '0;
			loaded_q <= 1'b0;
		end else begin
			state_q  <= state_nx;
			tap_q    <= tap_nx;
			loaded_q <= loaded_nx;
		end
	end

	assign busy = (state_q != ST_IDLE) || status.cfg_settle;
	assign req  = start && !busy;

	always_comb begin
		state_nx  = state_q;
		tap_nx    = tap_q;
		loaded_nx = loaded_q;
		cmd       = '0;
		cmd.tap   = tap_q;
		unique case (state_q)
			ST_IDLE: begin
				if (req && opcode == OP_LOAD && !loaded_q) begin
					cmd.load_wr = 1'b1;
					if (status.load_full) begin
						loaded_nx  = 1'b1;
						cmd.h_init = 1'b1;
						tap_nx     = '0;
						state_nx   = ST_H_ISSUE;
					end
				end else if (req && opcode == OP_DRAIN && loaded_q) begin
					cmd.d_init = 1'b1;
					tap_nx     = '0;
					state_nx   = ST_D_DIVW;
				end
			end
			ST_H_ISSUE, ST_V_ISSUE: begin
				cmd.issue   = 1'b1;
				cmd.acc_clr = tap_q == '0;
				if (tap_q == LAST_TAP) begin
					tap_nx   = '0;
					state_nx = (state_q == ST_H_ISSUE) ? ST_H_WAIT : ST_V_WAIT;
				end else begin
					tap_nx = tap_q + 1'b1;
				end
			end
			ST_H_WAIT: begin
				if (!status.pipe_busy) state_nx = ST_H_WRITE;
			end
			ST_H_WRITE: begin
				cmd.h_write = 1'b1;
				state_nx    = status.h_last ? ST_IDLE : ST_H_ISSUE;
			end
			ST_D_DIVW: begin
				if (status.div_done) state_nx = ST_V_ISSUE;
			end
			ST_V_WAIT: begin
				if (!status.pipe_busy) state_nx = ST_V_EMIT;
			end
			ST_V_EMIT: begin
				cmd.emit = 1'b1;
				if (status.drain_last) loaded_nx = 1'b0;
				state_nx = ST_IDLE;
			end
			default: state_nx = ST_IDLE;
		endcase
	end

	`SGB_ASSERT(a_emit_loaded, cmd.emit |-> loaded_q, "emit without a loaded frame")
	`SGB_ASSERT(a_pass_on_load, $rose(loaded_q) |-> state_q == ST_H_ISSUE, "row pass not started")
	`SGB_NEVER(a_idle_pipe, state_q == ST_IDLE && status.pipe_busy, "taps in flight while idle")
	`SGB_NEVER(a_load_busy, cmd.load_wr && loaded_q, "load accepted into a full frame")

endmodule

// File: rtl/core/separable_gaussian_blur.sv
// Channel   Signals                                  Direction
// request   start, busy, opcode, sample_in           in (busy out)
// result    strobe, blurred, frame_last              out, one cycle each
// config    cfg_valid, cfg_ready, cfg_index, cfg_data in (cfg_ready out)
//
// A load request writes its sample in the cycle it is accepted. The load that completes
// the frame runs the row pass, one sample at a time through one shared tap pipeline on
// the frame store. A drain request runs one bit-serial division by the row width, then
// the column taps through the same pipeline; busy holds off new requests in either pass.
// The result strobe comes in the cycle busy drops. A settle register, set by reset and
// by each register write, also holds busy high.
// Results cannot be stalled; arst_n clears control, the stores are not cleared.
module separable_gaussian_blur import sgb_pkg::*; #(
	parameter int RADIUS     = RADIUS_DEF,
	parameter int MAX_WIDTH  = MAX_WIDTH_DEF,
	parameter int MAX_HEIGHT = MAX_HEIGHT_DEF,
	parameter int CHANNELS   = CHANNELS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic                 opcode,
	input  logic [SAMPLE_W-1:0]  sample_in,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [COEF_W-1:0]    cfg_data,
	output logic                 strobe,
	output logic [SAMPLE_W-1:0]  blurred,
	output logic                 frame_last
);

	sgb_cmd_t    cmd;
	sgb_status_t status;

	assign cfg_ready = 1'b1;

	sgb_ctrl #(.RADIUS(RADIUS)) u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.opcode (opcode),
		.busy   (busy),
		.cmd    (cmd),
		.status (status)
	);

	sgb_datapath #(
		.RADIUS     (RADIUS),
		.MAX_WIDTH  (MAX_WIDTH),
		.MAX_HEIGHT (MAX_HEIGHT),
		.CHANNELS   (CHANNELS)
	) u_dp (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.status     (status),
		.sample_in  (sample_in),
		.cfg_valid  (cfg_valid),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.strobe     (strobe),
		.blurred    (blurred),
		.frame_last (frame_last)
	);

endmodule
